FILE: hdl/rscc_pkg.sv
// Shared types, codes and constants of the request splitter and tag classifier.
package rscc_pkg;

  localparam int SECTORS_PER_PAGE_DEF  = 8;
  localparam int CACHE_LINES_DEF       = 1024;
  localparam int SECTOR_BYTES_LOG2_DEF = 9;

  localparam int LBA_W  = 48;
  localparam int PAGE_W = 45;
  localparam int CNT_W  = 9;
  localparam int TXN_W  = 6;
  localparam int OFF_W  = 12;
  localparam int LEN_W  = 13;

  localparam int MAX_SECTORS   = 256;
  localparam int MAX_TXNS      = 33;
  localparam int DIV_STEP_BITS = 4;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [1:0] CLS_HIT        = 2'd0;
  localparam logic [1:0] CLS_MISS_DIRTY = 2'd1;
  localparam logic [1:0] CLS_MISS_CLEAN = 2'd2;

  localparam logic [1:0] ST_INVALID = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_DIRTY   = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [LBA_W-1:0]  first_sector;
    logic [CNT_W-1:0]  num_sectors;
    logic [15:0]       request_id;
    logic [15:0]       namespace_id;
    logic [7:0]        queue_number;
  } in_t;

  typedef struct packed {
    logic [1:0]        txn_kind;
    logic [PAGE_W-1:0] page_address;
    logic [OFF_W-1:0]  byte_offset;
    logic [LEN_W-1:0]  byte_length;
    logic [TXN_W-1:0]  txn_index;
    logic [TXN_W-1:0]  txn_total;
    logic [1:0]        hit_class;
    logic [PAGE_W-1:0] evicted_page;
    logic [15:0]       request_id_out;
    logic [15:0]       namespace_id_out;
    logic [7:0]        queue_number_out;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [PAGE_W-1:0] tag;
    logic [1:0]        status;
  } line_entry_t;

  // Bits needed to index n entries, at least one.
  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

FILE: hdl/rscc_cdiv.sv
// Division of an unsigned value by a constant: a shift for powers of two, else radix-16 steps.
module rscc_cdiv #(
  parameter int WIDTH   = rscc_pkg::LBA_W,
  parameter int DIVISOR = rscc_pkg::SECTORS_PER_PAGE_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [WIDTH-1:0]                        dividend,
  output logic                                    done,
  output logic [WIDTH-1:0]                        quot,
  output logic [rscc_pkg::idx_bits(DIVISOR)-1:0]  rem
);
  import rscc_pkg::*;

  localparam int RW      = idx_bits(DIVISOR);
  localparam bit IS_POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);

  generate
    if (IS_POW2) begin : g_shift
      localparam int SH = $clog2(DIVISOR);
      logic             done_r;
      logic [WIDTH-1:0] quot_r;
      logic [RW-1:0]    rem_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          quot_r <= dividend >> SH;
          rem_r  <= RW'(dividend & WIDTH'(DIVISOR - 1));
        end
      end

      assign done = done_r;
      assign quot = quot_r;
      assign rem  = rem_r;
    end else begin : g_iter
      localparam int STEPS = (WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
      localparam int WP    = STEPS * DIV_STEP_BITS;
      localparam int CW    = $clog2(STEPS + 1);

      logic          busy_r;
      logic          done_r;
      logic [CW-1:0] step_r;
      logic [WP-1:0] dvd_r;
      logic [WP-1:0] dvd_nxt;
      logic [WP-1:0] quo_r;
      logic [WP-1:0] quo_nxt;
      logic [RW-1:0] rem_r;
      logic [RW-1:0] rem_nxt;

      // Restoring division, most significant dividend bit first.
      always_comb begin
        logic [RW:0] t;
        dvd_nxt = dvd_r;
        quo_nxt = quo_r;
        rem_nxt = rem_r;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
          t       = {rem_nxt, dvd_nxt[WP-1]};
          dvd_nxt = dvd_nxt << 1;
          if (t >= (RW+1)'(DIVISOR)) begin
            rem_nxt = RW'(t - (RW+1)'(DIVISOR));
            quo_nxt = {quo_nxt[WP-2:0], 1'b1};
          end else begin
            rem_nxt = RW'(t);
            quo_nxt = {quo_nxt[WP-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
          step_r <= '0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
            step_r <= CW'(STEPS);
          end else if (busy_r) begin
            step_r <= step_r - CW'(1);
            if (step_r == CW'(1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          dvd_r <= WP'(dividend);
          quo_r <= '0;
          rem_r <= '0;
        end else if (busy_r) begin
          dvd_r <= dvd_nxt;
          quo_r <= quo_nxt;
          rem_r <= rem_nxt;
        end
      end

      assign done = done_r;
      assign quot = quo_r[WIDTH-1:0];
      assign rem  = rem_r;
    end
  endgenerate

endmodule

FILE: hdl/rscc_split.sv
// Request front end: page and line arithmetic and the page-aligned transaction sequencer.
module rscc_split #(
  parameter int SECTORS_PER_PAGE  = rscc_pkg::SECTORS_PER_PAGE_DEF,
  parameter int CACHE_LINES       = rscc_pkg::CACHE_LINES_DEF,
  parameter int SECTOR_BYTES_LOG2 = rscc_pkg::SECTOR_BYTES_LOG2_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  rscc_pkg::in_t                               in_data,
  input  logic                                        store_busy,
  output logic                                        txn_valid,
  input  logic                                        txn_ready,
  output rscc_pkg::out_t                              txn_data,
  output logic [rscc_pkg::idx_bits(CACHE_LINES)-1:0]  txn_line
);
  import rscc_pkg::*;

  localparam int PO_W   = idx_bits(SECTORS_PER_PAGE);
  localparam int LINE_W = idx_bits(CACHE_LINES);
  localparam int X_W    = $clog2(SECTORS_PER_PAGE + MAX_SECTORS);
  localparam int RCP_SH = X_W + PO_W + 2;
  localparam int RCP_W  = RCP_SH + 1;
  localparam int PROD_W = X_W + RCP_W;
  localparam int OW     = PO_W + SECTOR_BYTES_LOG2;
  localparam int LW     = CNT_W + SECTOR_BYTES_LOG2;
  localparam logic [RCP_W-1:0] RCP_MUL =
    RCP_W'(((1 << RCP_SH) + SECTORS_PER_PAGE - 1) / SECTORS_PER_PAGE);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_LINE = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  in_t               req_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              flush_r;
  logic              write_r;
  logic [PAGE_W-1:0] page_r;
  logic [PO_W-1:0]   po_r;
  logic [LINE_W-1:0] line_r;
  logic [PROD_W-1:0] prod_r;
  logic [TXN_W-1:0]  n_r;
  logic [TXN_W-1:0]  idx_r;

  logic              in_acc;
  logic [CNT_W-1:0]  cnt_sat;
  logic              div1_start;
  logic              div1_done;
  logic [LBA_W-1:0]  div1_quot;
  logic [PO_W-1:0]   div1_rem;
  logic              div2_done;
  logic [PAGE_W-1:0] div2_quot;
  logic [LINE_W-1:0] div2_rem;
  logic [X_W-1:0]    span_m1;
  logic [PROD_W-1:0] prod;
  logic [X_W-1:0]    pages_m1;
  logic [TXN_W-1:0]  n_calc;
  logic [CNT_W-1:0]  avail;
  logic [CNT_W-1:0]  sz;
  logic              last_txn;
  logic              txn_acc;

  assign in_stall = (state_r != S_IDLE) || store_busy;
  assign in_acc   = in_valid && !in_stall;
  assign cnt_sat  = (in_data.num_sectors > CNT_W'(MAX_SECTORS)) ?
                    CNT_W'(MAX_SECTORS) : in_data.num_sectors;
  assign div1_start = in_acc && (in_data.operation != OP_FLUSH) && (cnt_sat != '0);

  rscc_cdiv #(
    .WIDTH   (LBA_W),
    .DIVISOR (SECTORS_PER_PAGE)
  ) u_page_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div1_start),
    .dividend (in_data.first_sector),
    .done     (div1_done),
    .quot     (div1_quot),
    .rem      (div1_rem)
  );

  rscc_cdiv #(
    .WIDTH   (PAGE_W),
    .DIVISOR (CACHE_LINES)
  ) u_line_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div1_done),
    .dividend (div1_quot[PAGE_W-1:0]),
    .done     (div2_done),
    .quot     (div2_quot),
    .rem      (div2_rem)
  );

  // Pages touched minus one is (offset + count - 1) / SECTORS_PER_PAGE, taken by
  // reciprocal multiplication; the product is registered before it is used.
  assign span_m1  = X_W'(div1_rem) + X_W'(cnt_r) - X_W'(1);
  assign prod     = PROD_W'(span_m1) * PROD_W'(RCP_MUL);
  assign pages_m1 = X_W'(prod_r >> RCP_SH);
  assign n_calc   = (pages_m1 >= X_W'(MAX_TXNS)) ? TXN_W'(MAX_TXNS) :
                    TXN_W'(pages_m1 + X_W'(1));

  assign avail    = CNT_W'(SECTORS_PER_PAGE) - CNT_W'(po_r);
  assign sz       = (avail < cnt_r) ? avail : cnt_r;
  assign last_txn = (idx_r == n_r - TXN_W'(1));

  assign txn_valid = (state_r == S_EMIT);
  assign txn_acc   = txn_valid && txn_ready;
  assign txn_line  = line_r;

  always_comb begin
    txn_data                  = '0;
    txn_data.request_id_out   = req_r.request_id;
    txn_data.namespace_id_out = req_r.namespace_id;
    txn_data.queue_number_out = req_r.queue_number;
    if (flush_r) begin
      txn_data.txn_kind  = OP_FLUSH;
      txn_data.txn_total = TXN_W'(1);
      txn_data.last      = 1'b1;
    end else begin
      txn_data.txn_kind     = write_r ? OP_WRITE : OP_READ;
      txn_data.page_address = page_r;
      txn_data.byte_offset  = OFF_W'(OW'(po_r) << SECTOR_BYTES_LOG2);
      txn_data.byte_length  = LEN_W'(LW'(sz) << SECTOR_BYTES_LOG2);
      txn_data.txn_index    = idx_r;
      txn_data.txn_total    = n_r;
      txn_data.last         = last_txn;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.operation == OP_FLUSH) begin
            state_nxt = S_EMIT;
          end else if (cnt_sat != '0) begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div1_done) begin
          state_nxt = S_LINE;
        end
      end
      S_LINE: begin
        if (div2_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (txn_acc && (flush_r || last_txn)) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r   <= in_data;
      cnt_r   <= cnt_sat;
      flush_r <= (in_data.operation == OP_FLUSH);
      write_r <= (in_data.operation == OP_WRITE);
      idx_r   <= '0;
      n_r     <= TXN_W'(1);
    end
    if (div1_done) begin
      page_r <= div1_quot[PAGE_W-1:0];
      po_r   <= div1_rem;
      prod_r <= prod;
    end
    if (div2_done) begin
      line_r <= div2_rem;
      n_r    <= n_calc;
    end
    if (txn_acc) begin
      // Every page after the first starts on a page boundary.
      idx_r  <= idx_r + TXN_W'(1);
      page_r <= page_r + PAGE_W'(1);
      line_r <= (line_r == LINE_W'(CACHE_LINES - 1)) ? '0 : line_r + LINE_W'(1);
      cnt_r  <= cnt_r - sz;
      po_r   <= '0;
    end
  end

  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (n_r != '0) && (idx_r < n_r))
    else $error("transaction index ran past the transaction total");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div1_done |-> (state_r == S_DIV))
    else $error("page division finished outside its state");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (txn_acc && txn_data.last) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after the last transaction");

endmodule

FILE: hdl/rscc_tag_store.sv
// Direct-mapped shadow tag memory with lookup, read-modify-write and result register.
module rscc_tag_store #(
  parameter int CACHE_LINES = rscc_pkg::CACHE_LINES_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  output logic                                        busy,
  input  logic                                        txn_valid,
  output logic                                        txn_ready,
  input  rscc_pkg::out_t                              txn_data,
  input  logic [rscc_pkg::idx_bits(CACHE_LINES)-1:0]  txn_line,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output rscc_pkg::out_t                              out_data
);
  import rscc_pkg::*;

  localparam int LINE_W = idx_bits(CACHE_LINES);

  line_entry_t       tag_mem [CACHE_LINES];

  logic              clr_active_r;
  logic [LINE_W-1:0] clr_idx_r;
  logic              rs_valid_r;
  out_t              rs_txn_r;
  logic [LINE_W-1:0] rs_line_r;
  line_entry_t       rd_data_r;
  logic              fwd_valid_r;
  logic [LINE_W-1:0] fwd_line_r;
  line_entry_t       fwd_entry_r;
  logic              out_valid_r;
  out_t              out_r;

  logic              fire;
  logic              txn_acc;
  logic              bypass;
  logic              is_wr;
  line_entry_t       cur;
  logic              hit;
  logic [1:0]        cls;
  line_entry_t       new_entry;
  out_t              res;
  logic              wr_en;
  logic [LINE_W-1:0] wr_addr;
  line_entry_t       wr_data;

  assign busy      = clr_active_r;
  assign fire      = rs_valid_r && (!out_valid_r || !out_stall);
  assign txn_ready = !clr_active_r && (!rs_valid_r || fire);
  assign txn_acc   = txn_valid && txn_ready;
  assign bypass    = (rs_txn_r.txn_kind == OP_FLUSH);
  assign is_wr     = (rs_txn_r.txn_kind == OP_WRITE);

  // The memory read for this transaction was issued while the previous one
  // wrote back, so the line may be stale; the last write-back wins.
  assign cur = (fwd_valid_r && (fwd_line_r == rs_line_r)) ? fwd_entry_r : rd_data_r;
  assign hit = (cur.tag == rs_txn_r.page_address) && (cur.status != ST_INVALID);

  always_comb begin
    priority if (hit) begin
      cls = CLS_HIT;
    end else if (cur.status == ST_DIRTY) begin
      cls = CLS_MISS_DIRTY;
    end else begin
      cls = CLS_MISS_CLEAN;
    end
  end

  always_comb begin
    new_entry.tag = rs_txn_r.page_address;
    if (is_wr || (hit && (cur.status == ST_DIRTY))) begin
      new_entry.status = ST_DIRTY;
    end else begin
      new_entry.status = ST_VALID;
    end
  end

  always_comb begin
    res = rs_txn_r;
    if (!bypass) begin
      res.hit_class    = cls;
      res.evicted_page = cur.tag;
    end
  end

  assign wr_en   = clr_active_r || (fire && !bypass);
  assign wr_addr = clr_active_r ? clr_idx_r : rs_line_r;
  assign wr_data = clr_active_r ? line_entry_t'('0) : new_entry;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= wr_data;
    end
    if (txn_acc) begin
      rd_data_r <= tag_mem[txn_line];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      rs_valid_r   <= 1'b0;
      fwd_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + LINE_W'(1);
        if (clr_idx_r == LINE_W'(CACHE_LINES - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (txn_acc) begin
        rs_valid_r <= 1'b1;
      end else if (fire) begin
        rs_valid_r <= 1'b0;
      end
      if (fire && !bypass) begin
        fwd_valid_r <= 1'b1;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (txn_acc) begin
      rs_txn_r  <= txn_data;
      rs_line_r <= txn_line;
    end
    if (fire && !bypass) begin
      fwd_line_r  <= rs_line_r;
      fwd_entry_r <= new_entry;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_lookup_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !rs_valid_r)
    else $error("lookup in flight during the clearing pass");

  a_flush_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && bypass) |=> (out_r.hit_class == CLS_HIT) && (out_r.evicted_page == '0))
    else $error("flush transaction picked up lookup fields");

  a_write_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_wr) |=> fwd_valid_r && (fwd_entry_r.status == ST_DIRTY))
    else $error("write transaction did not leave its line dirty");

endmodule

FILE: hdl/request_split_cache_classify.sv
// Top level of the request splitter with direct-mapped shadow tag classification.
// After reset the block clears the tag memory, one line per cycle, and holds
// in_stall high meanwhile. A read or write request is then split into one
// transaction per page it touches (at most 33); each transaction is looked up in
// the tag memory, classed as hit, dirty miss or clean miss, and the line is
// rewritten. A flush gives one transaction and leaves the tags alone; a read or
// write with a zero count gives none. In the front end a request goes through the
// page division, the line division and the loading of the sequencer, then into the
// tag lookup at one transaction per cycle while the lookup is ready for it. A page
// size that is not a power of two makes the page division iterate in radix-16 steps,
// and a line count that is not a power of two does the same for the line index. A
// flush skips both divisions. Results leave through a register, so the next request
// is taken while the last results of the previous one are still waiting at the output.
module request_split_cache_classify #(
  parameter int SECTORS_PER_PAGE  = rscc_pkg::SECTORS_PER_PAGE_DEF,
  parameter int CACHE_LINES       = rscc_pkg::CACHE_LINES_DEF,
  parameter int SECTOR_BYTES_LOG2 = rscc_pkg::SECTOR_BYTES_LOG2_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rscc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rscc_pkg::out_t out_data
);
  import rscc_pkg::*;

  localparam int LINE_W = idx_bits(CACHE_LINES);

  logic              store_busy;
  logic              txn_valid;
  logic              txn_ready;
  out_t              txn_data;
  logic [LINE_W-1:0] txn_line;

  rscc_split #(
    .SECTORS_PER_PAGE  (SECTORS_PER_PAGE),
    .CACHE_LINES       (CACHE_LINES),
    .SECTOR_BYTES_LOG2 (SECTOR_BYTES_LOG2)
  ) u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .store_busy (store_busy),
    .txn_valid  (txn_valid),
    .txn_ready  (txn_ready),
    .txn_data   (txn_data),
    .txn_line   (txn_line)
  );

  rscc_tag_store #(
    .CACHE_LINES (CACHE_LINES)
  ) u_tag_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (store_busy),
    .txn_valid (txn_valid),
    .txn_ready (txn_ready),
    .txn_data  (txn_data),
    .txn_line  (txn_line),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: bench/request_split_cache_classify_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the request splitter with shadow tag classification.
module request_split_cache_classify_test;
  import rscc_pkg::*;

  localparam int SPP             = SECTORS_PER_PAGE_DEF;
  localparam int LINES           = CACHE_LINES_DEF;
  localparam int BYTES_LOG2      = SECTOR_BYTES_LOG2_DEF;
  localparam int RANDOM_REQUESTS = 110;
  localparam int STUCK_LIMIT     = 4000;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 40;

  // The block treats the unused operation code like a read.
  localparam logic [1:0] OP_ALIAS_READ = 2'd3;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } stim_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic [PAGE_W-1:0] shadow_tag [LINES];
  logic [1:0]        shadow_status [LINES];
  out_t              pending_txns [$];
  stim_row_t         directed_rows [$];
  int                mismatches   = 0;
  int                results_seen = 0;
  bit                hold_request = 1'b0;
  bit                hold_done    = 1'b0;

  request_split_cache_classify DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // Splits one request into page transactions, classifies each against the shadow
  // tags, queues the expected transactions and returns how many were queued.
  function automatic int split_and_classify(input in_t req);
    logic [63:0]       lba, count, done, off, run, page;
    logic [63:0]       pages [MAX_TXNS];
    logic [63:0]       offs [MAX_TXNS];
    logic [63:0]       runs [MAX_TXNS];
    logic [PAGE_W-1:0] old_tag;
    logic [1:0]        old_st;
    logic              hit;
    bit                is_write;
    int                n, line;
    out_t              t;
    t = '0;
    t.request_id_out   = req.request_id;
    t.namespace_id_out = req.namespace_id;
    t.queue_number_out = req.queue_number;
    if (req.operation == OP_FLUSH) begin
      t.txn_kind  = OP_FLUSH;
      t.txn_total = TXN_W'(1);
      t.last      = 1'b1;
      pending_txns.push_back(t);
      return 1;
    end
    is_write = (req.operation == OP_WRITE);
    lba      = 64'(req.first_sector);
    count    = (req.num_sectors > MAX_SECTORS) ? 64'(MAX_SECTORS) : 64'(req.num_sectors);
    done     = 0;
    n        = 0;
    while (done < count && n < MAX_TXNS) begin
      off = lba % SPP;
      run = SPP - off;
      if (done + run > count) begin
        run = count - done;
      end
      pages[n] = (lba / SPP) & ((64'd1 << PAGE_W) - 1);
      offs[n]  = off;
      runs[n]  = run;
      lba      = lba + run;
      done     = done + run;
      n++;
    end
    for (int k = 0; k < n; k++) begin
      page    = pages[k];
      line    = int'(page % LINES);
      old_tag = shadow_tag[line];
      old_st  = shadow_status[line];
      hit     = (old_tag == page[PAGE_W-1:0]) && (old_st != ST_INVALID);
      if (hit) begin
        t.hit_class = CLS_HIT;
      end else if (old_st == ST_DIRTY) begin
        t.hit_class = CLS_MISS_DIRTY;
      end else begin
        t.hit_class = CLS_MISS_CLEAN;
      end
      shadow_tag[line] = page[PAGE_W-1:0];
      if (is_write) begin
        shadow_status[line] = ST_DIRTY;
      end else if (!(hit && old_st == ST_DIRTY)) begin
        shadow_status[line] = ST_VALID;
      end
      t.txn_kind     = is_write ? OP_WRITE : OP_READ;
      t.page_address = page[PAGE_W-1:0];
      t.byte_offset  = OFF_W'(offs[k] << BYTES_LOG2);
      t.byte_length  = LEN_W'(runs[k] << BYTES_LOG2);
      t.txn_index    = TXN_W'(k);
      t.txn_total    = TXN_W'(n);
      t.evicted_page = old_tag;
      t.last         = (k == n - 1);
      pending_txns.push_back(t);
    end
    return n;
  endfunction

  function automatic in_t mk_req(input logic [1:0] op, input logic [LBA_W-1:0] lba,
                                 input logic [CNT_W-1:0] cnt, input logic [15:0] rid,
                                 input logic [15:0] nsid, input logic [7:0] qn);
    in_t r;
    r.operation    = op;
    r.first_sector = lba;
    r.num_sectors  = cnt;
    r.request_id   = rid;
    r.namespace_id = nsid;
    r.queue_number = qn;
    return r;
  endfunction

  function automatic void add_row(input in_t req, input bit typed = 1'b0,
                                  input out_t want = '0);
    directed_rows.push_back('{req, typed, want});
  endfunction

  // Most random requests land on a few pages that share cache lines, so hits,
  // dirty evictions and clean misses all show up; the rest roam the whole range.
  function automatic in_t random_request();
    in_t         r;
    int          pick;
    logic [63:0] page;
    pick = $urandom_range(99);
    if (pick < 40) begin
      r.operation = OP_READ;
    end else if (pick < 75) begin
      r.operation = OP_WRITE;
    end else if (pick < 85) begin
      r.operation = OP_FLUSH;
    end else begin
      r.operation = OP_ALIAS_READ;
    end
    pick = $urandom_range(99);
    if (pick < 8) begin
      r.num_sectors = '0;
    end else if (pick < 75) begin
      r.num_sectors = CNT_W'($urandom_range(24, 1));
    end else if (pick < 93) begin
      r.num_sectors = CNT_W'($urandom_range(255, 25));
    end else begin
      r.num_sectors = CNT_W'($urandom_range(511, 256));
    end
    if ($urandom_range(99) < 60) begin
      page           = (64'($urandom_range(3)) << 10) | 64'($urandom_range(15));
      r.first_sector = LBA_W'(page * SPP + 64'($urandom_range(SPP - 1)));
    end else begin
      r.first_sector = LBA_W'({$urandom, $urandom});
    end
    r.request_id   = 16'($urandom);
    r.namespace_id = 16'($urandom);
    r.queue_number = 8'($urandom);
    return r;
  endfunction

  task automatic send_request(input in_t req, input bit steady, output int produced);
    while (!steady && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    produced = split_and_classify(req);
  endtask

  task automatic show_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) begin
      $display("  %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  task automatic check_txn(input out_t got, input out_t want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch on transaction %0d of request %0h:", want.txn_index,
                 want.request_id_out);
        show_field("txn_kind", 64'(want.txn_kind), 64'(got.txn_kind));
        show_field("page_address", 64'(want.page_address), 64'(got.page_address));
        show_field("byte_offset", 64'(want.byte_offset), 64'(got.byte_offset));
        show_field("byte_length", 64'(want.byte_length), 64'(got.byte_length));
        show_field("txn_index", 64'(want.txn_index), 64'(got.txn_index));
        show_field("txn_total", 64'(want.txn_total), 64'(got.txn_total));
        show_field("hit_class", 64'(want.hit_class), 64'(got.hit_class));
        show_field("evicted_page", 64'(want.evicted_page), 64'(got.evicted_page));
        show_field("request_id_out", 64'(want.request_id_out),
                   64'(got.request_id_out));
        show_field("namespace_id_out", 64'(want.namespace_id_out),
                   64'(got.namespace_id_out));
        show_field("queue_number_out", 64'(want.queue_number_out),
                   64'(got.queue_number_out));
        show_field("last", 64'(want.last), 64'(got.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_txns.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Transaction with nothing expected: %p", out_data);
        end
      end else begin
        check_txn(out_data, pending_txns.pop_front());
      end
    end
  end

  // Result side: random stalls, one long hold-off once the random part starts, and
  // a window with no stalls at all.
  initial begin
    @(posedge clk);
    while (!rst_n) begin
      @(posedge clk);
    end
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= (results_seen >= 200 && results_seen < 400) ? 1'b0 :
                     ($urandom_range(99) < 33);
        @(posedge clk);
      end
    end
  end

  // The clearing pass after reset and the hold-off both fit well inside the limit.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int produced;
    int sent;
    for (int i = 0; i < LINES; i++) begin
      shadow_tag[i]    = '0;
      shadow_status[i] = ST_INVALID;
    end

    // Cold miss, then a hit on the same page.
    add_row(mk_req(OP_READ, 48'd0, 9'd1, 16'h0001, 16'h0001, 8'h01), 1'b1,
            out_t'{OP_READ, 45'd0, 12'd0, 13'd512, 6'd0, 6'd1, CLS_MISS_CLEAN, 45'd0,
                   16'h0001, 16'h0001, 8'h01, 1'b1});
    add_row(mk_req(OP_READ, 48'd0, 9'd1, 16'h0002, 16'h0000, 8'h00), 1'b1,
            out_t'{OP_READ, 45'd0, 12'd0, 13'd512, 6'd0, 6'd1, CLS_HIT, 45'd0,
                   16'h0002, 16'h0000, 8'h00, 1'b1});
    add_row(mk_req(OP_WRITE, 48'd0, 9'd8, 16'h0003, 16'h0010, 8'h02));
    // A read hit on a dirty line must leave it dirty.
    add_row(mk_req(OP_READ, 48'd2, 9'd1, 16'h0004, 16'h0011, 8'h03));
    add_row(mk_req(OP_WRITE, 48'd8192, 9'd1, 16'h0005, 16'h0012, 8'h04));
    add_row(mk_req(OP_READ, 48'd0, 9'd8, 16'h0006, 16'h0013, 8'h05));
    // Last sector of the address space, on a line not yet touched.
    add_row(mk_req(OP_READ, 48'hffff_ffff_ffff, 9'd1, 16'hffff, 16'hffff, 8'hff), 1'b1,
            out_t'{OP_READ, 45'h1fff_ffff_ffff, 12'd3584, 13'd512, 6'd0, 6'd1,
                   CLS_MISS_CLEAN, 45'd0, 16'hffff, 16'hffff, 8'hff, 1'b1});
    // Flushes pass straight through, whatever their count.
    add_row(mk_req(OP_FLUSH, 48'hffff_ffff_ffff, 9'd0, 16'hffff, 16'h0000, 8'hff), 1'b1,
            out_t'{OP_FLUSH, 45'd0, 12'd0, 13'd0, 6'd0, 6'd1, CLS_HIT, 45'd0,
                   16'hffff, 16'h0000, 8'hff, 1'b1});
    add_row(mk_req(OP_FLUSH, 48'h0000_0000_0123, 9'd256, 16'h0000, 16'hffff, 8'h00), 1'b1,
            out_t'{OP_FLUSH, 45'd0, 12'd0, 13'd0, 6'd0, 6'd1, CLS_HIT, 45'd0,
                   16'h0000, 16'hffff, 8'h00, 1'b1});
    // Zero counts give nothing.
    add_row(mk_req(OP_READ, 48'd100, 9'd0, 16'h0009, 16'h0001, 8'h10));
    add_row(mk_req(OP_WRITE, 48'd200, 9'd0, 16'h000a, 16'h0002, 8'h20));
    add_row(mk_req(OP_ALIAS_READ, 48'd5, 9'd12, 16'h000b, 16'h0003, 8'h30));
    add_row(mk_req(OP_ALIAS_READ, 48'd0, 9'd8, 16'h000c, 16'h0004, 8'h40));
    // Range that wraps past the top of the address space.
    add_row(mk_req(OP_WRITE, 48'hffff_ffff_fff4, 9'd20, 16'h000d, 16'h0005, 8'h50));
    // Full-size requests: unaligned gives the most transactions, aligned one fewer.
    add_row(mk_req(OP_READ, 48'd3, 9'd256, 16'h000e, 16'h0006, 8'h60));
    add_row(mk_req(OP_WRITE, 48'h1000, 9'd256, 16'h000f, 16'h0007, 8'h70));
    // Counts above the maximum saturate.
    add_row(mk_req(OP_READ, 48'd7, 9'd511, 16'h0010, 16'h0008, 8'h80));
    add_row(mk_req(OP_WRITE, 48'h5555_5555_5555, 9'h155, 16'h5555, 16'haaaa, 8'h55));
    add_row(mk_req(OP_READ, 48'haaaa_aaaa_aaaa, 9'h0aa, 16'haaaa, 16'h5555, 8'haa));
    add_row(mk_req(OP_WRITE, 48'd8184, 9'd16, 16'h0011, 16'h0009, 8'h90));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, 1'b0, produced);
      if (directed_rows[i].typed) begin
        void'(pending_txns.pop_back());
        pending_txns.push_back(directed_rows[i].want);
      end
    end

    hold_request = 1'b1;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      send_request(random_request(), sent >= 30 && sent < 70, produced);
      if (produced > 0) begin
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (pending_txns.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
